// File: rtl/core/ckb_pkg.sv
// ----------------------------------------------------------------------------
// ckb_pkg
// Shared types and constants of the clipped, color-keyed blitter.
// ----------------------------------------------------------------------------
package ckb_pkg;

  localparam int unsigned MaxDim  = 4096;
  localparam int unsigned DimW    = $clog2(MaxDim + 1);
  localparam int unsigned CntW    = $clog2(MaxDim);
  localparam int unsigned OffW    = 14;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned PixW    = 32;
  localparam int unsigned AddrW   = 24;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned CfgW    = 14;
  localparam int unsigned PosW    = OffW + 1;
  localparam int unsigned ProdW   = CntW + DimW;

  localparam logic [PixW-1:0] KeyMask = 32'h0000_00ff;

  // Register indexes on the configuration port.
  localparam logic [IdxW-1:0] REG_DEST_WIDTH    = 3'd0;
  localparam logic [IdxW-1:0] REG_DEST_HEIGHT   = 3'd1;
  localparam logic [IdxW-1:0] REG_SOURCE_WIDTH  = 3'd2;
  localparam logic [IdxW-1:0] REG_SOURCE_HEIGHT = 3'd3;
  localparam logic [IdxW-1:0] REG_OFFSET_X      = 3'd4;
  localparam logic [IdxW-1:0] REG_OFFSET_Y      = 3'd5;
  localparam logic [IdxW-1:0] REG_BLIT_MODE     = 3'd6;

  // Blit modes.
  localparam logic [ModeW-1:0] MODE_COPY = 2'd0;
  localparam logic [ModeW-1:0] MODE_KEY  = 2'd1;

  // Configuration as seen by the datapath, dimensions already clamped.
  typedef struct packed {
    logic [DimW-1:0]        dest_width;
    logic [DimW-1:0]        dest_height;
    logic [DimW-1:0]        source_width;
    logic [DimW-1:0]        source_height;
    logic signed [OffW-1:0] offset_x;
    logic signed [OffW-1:0] offset_y;
    logic [ModeW-1:0]       blit_mode;
  } ckb_cfg_t;

  // Raster position of one source pixel.
  typedef struct packed {
    logic [CntW-1:0] column;
    logic [CntW-1:0] row;
    logic            frame_end;
  } ckb_pos_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] lim;
    lim = DimW'(MaxDim);
    return (v > lim) ? lim : v;
  endfunction

endpackage

// File: rtl/core/ckb_cfg_regs.sv
// ----------------------------------------------------------------------------
// ckb_cfg_regs
// Configuration register file; dimensions are clamped on the way out.
// ----------------------------------------------------------------------------
module ckb_cfg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ckb_pkg::IdxW-1:0]  cfg_index_i,
  input  logic [ckb_pkg::CfgW-1:0]  cfg_data_i,
  output ckb_pkg::ckb_cfg_t         cfg_o
);
  import ckb_pkg::*;

  logic [DimW-1:0]  dw_q, dh_q, sw_q, sh_q;
  logic [OffW-1:0]  ox_q, oy_q;
  logic [ModeW-1:0] mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dw_q   <= '0;
      dh_q   <= '0;
      sw_q   <= '0;
      sh_q   <= '0;
      ox_q   <= '0;
      oy_q   <= '0;
      mode_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DEST_WIDTH:    dw_q   <= cfg_data_i[DimW-1:0];
        REG_DEST_HEIGHT:   dh_q   <= cfg_data_i[DimW-1:0];
        REG_SOURCE_WIDTH:  sw_q   <= cfg_data_i[DimW-1:0];
        REG_SOURCE_HEIGHT: sh_q   <= cfg_data_i[DimW-1:0];
        REG_OFFSET_X:      ox_q   <= cfg_data_i[OffW-1:0];
        REG_OFFSET_Y:      oy_q   <= cfg_data_i[OffW-1:0];
        REG_BLIT_MODE:     mode_q <= cfg_data_i[ModeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.dest_width    = clamp_dim(dw_q);
    cfg_o.dest_height   = clamp_dim(dh_q);
    cfg_o.source_width  = clamp_dim(sw_q);
    cfg_o.source_height = clamp_dim(sh_q);
    cfg_o.offset_x      = ox_q;
    cfg_o.offset_y      = oy_q;
    cfg_o.blit_mode     = mode_q;
  end

endmodule

// File: rtl/core/ckb_raster_ctr.sv
// ----------------------------------------------------------------------------
// ckb_raster_ctr
// Source column and row counters, advanced once per accepted pixel.
// ----------------------------------------------------------------------------
module ckb_raster_ctr (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      advance_i,
  input  logic [ckb_pkg::DimW-1:0]  source_width_i,
  input  logic [ckb_pkg::DimW-1:0]  source_height_i,
  output ckb_pkg::ckb_pos_t         pos_o
);
  import ckb_pkg::*;

  logic [CntW-1:0] col_q, col_d;
  logic [CntW-1:0] row_q, row_d;
  logic            last_col;
  logic            last_row;

  // A width or height of zero makes every position the last one.
  assign last_col = ({1'b0, col_q} + DimW'(1)) >= source_width_i;
  assign last_row = ({1'b0, row_q} + DimW'(1)) >= source_height_i;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (advance_i) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + CntW'(1);
      end else begin
        col_d = col_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign pos_o.column    = col_q;
  assign pos_o.row       = row_q;
  assign pos_o.frame_end = last_col & last_row;

endmodule

// File: rtl/core/ckb_clip_addr.sv
// ----------------------------------------------------------------------------
// ckb_clip_addr
// Clip test, color key and destination address of one pixel.
// ----------------------------------------------------------------------------
module ckb_clip_addr (
  input  ckb_pkg::ckb_cfg_t         cfg_i,
  input  ckb_pkg::ckb_pos_t         pos_i,
  input  logic [ckb_pkg::PixW-1:0]  pixel_i,
  output logic                      write_enable_o,
  output logic [ckb_pkg::AddrW-1:0] dest_address_o
);
  import ckb_pkg::*;

  logic [PosW-1:0]  dc;
  logic [PosW-1:0]  dr;
  logic             inside_src;
  logic             inside_dst;
  logic             mode_ok;
  logic [ProdW-1:0] addr_full;

  // Destination position as a two's complement sum of offset and counter.
  assign dc = {cfg_i.offset_x[OffW-1], cfg_i.offset_x} + PosW'(pos_i.column);
  assign dr = {cfg_i.offset_y[OffW-1], cfg_i.offset_y} + PosW'(pos_i.row);

  assign inside_src = ({1'b0, pos_i.column} < cfg_i.source_width) &&
                      ({1'b0, pos_i.row} < cfg_i.source_height);
  assign inside_dst = !dc[PosW-1] && !dr[PosW-1] &&
                      (dc[PosW-2:0] < OffW'(cfg_i.dest_width)) &&
                      (dr[PosW-2:0] < OffW'(cfg_i.dest_height));
  assign mode_ok = (cfg_i.blit_mode == MODE_COPY) ||
                   ((cfg_i.blit_mode == MODE_KEY) && ((pixel_i & KeyMask) != '0));

  assign write_enable_o = inside_src && inside_dst && mode_ok;

  // Inside the destination both coordinates are below MaxDim.
  assign addr_full = ProdW'(dr[CntW-1:0]) * ProdW'(cfg_i.dest_width) +
                     ProdW'(dc[CntW-1:0]);

  assign dest_address_o = write_enable_o ? addr_full[AddrW-1:0] : '0;

endmodule

// File: rtl/core/clipped_keyed_blit.sv
// ----------------------------------------------------------------------------
// clipped_keyed_blit
// Clipped bit-block transfer with optional color key on the low byte.
// ----------------------------------------------------------------------------
// Source pixels arrive in raster order, one beat per clock while in_ready_o
// is high, and each one yields exactly one result beat: write flag, linear
// destination address, the pixel and a frame end mark on the last source
// pixel. The block sustains one pixel per clock while the output is not
// stalled; the pipeline is the input register followed by the result register,
// and the path between them holds the clip compares and one 12x13 multiply-add
// for the address. Configuration writes are taken in every cycle and must only
// happen while no pixel is in flight.
module clipped_keyed_blit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [ckb_pkg::IdxW-1:0]  cfg_index_i,
  input  logic [ckb_pkg::CfgW-1:0]  cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [ckb_pkg::PixW-1:0]  source_pixel_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      write_enable_o,
  output logic [ckb_pkg::AddrW-1:0] dest_address_o,
  output logic [ckb_pkg::PixW-1:0]  dest_pixel_o,
  output logic                      frame_end_o
);
  import ckb_pkg::*;

  ckb_cfg_t        cfg;
  ckb_pos_t        pos;
  logic            in_fire;

  logic            s1_valid_q;
  ckb_pos_t        s1_pos_q;
  logic [PixW-1:0] s1_pix_q;
  logic            s1_move;

  logic            s2_valid_q;
  logic            s2_free;
  logic            we_d;
  logic [AddrW-1:0] addr_d;
  logic            we_q;
  logic [AddrW-1:0] addr_q;
  logic [PixW-1:0] pix_q;
  logic            fend_q;

  assign cfg_ready_o = 1'b1;

  ckb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Handshake of the two-stage pipeline.
  assign s2_free    = !s2_valid_q || out_ready_i;
  assign s1_move    = s1_valid_q && s2_free;
  assign in_ready_o = !s1_valid_q || s2_free;
  assign in_fire    = in_valid_i && in_ready_o;

  ckb_raster_ctr u_ctr (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .advance_i       (in_fire),
    .source_width_i  (cfg.source_width),
    .source_height_i (cfg.source_height),
    .pos_o           (pos)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pos_q <= pos;
      s1_pix_q <= source_pixel_i;
    end
  end

  ckb_clip_addr u_clip (
    .cfg_i          (cfg),
    .pos_i          (s1_pos_q),
    .pixel_i        (s1_pix_q),
    .write_enable_o (we_d),
    .dest_address_o (addr_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_free) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      we_q   <= we_d;
      addr_q <= addr_d;
      pix_q  <= s1_pix_q;
      fend_q <= s1_pos_q.frame_end;
    end
  end

  assign out_valid_o    = s2_valid_q;
  assign write_enable_o = we_q;
  assign dest_address_o = addr_q;
  assign dest_pixel_o   = pix_q;
  assign frame_end_o    = fend_q;

endmodule

// File: rtl/core/ckb_checker.sv
// ----------------------------------------------------------------------------
// ckb_checker
// Port-level checks of the blitter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ckb_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      cfg_ready_o,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic                      write_enable_o,
  input logic [ckb_pkg::AddrW-1:0] dest_address_o,
  input logic [ckb_pkg::PixW-1:0]  dest_pixel_o,
  input logic                      frame_end_o
);
  import ckb_pkg::*;

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(write_enable_o) &&
      $stable(dest_address_o) && $stable(dest_pixel_o) && $stable(frame_end_o))
    else $error("result beat changed while stalled");

  // Pixels that are not written carry a zero address.
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_enable_o |-> dest_address_o == '0)
    else $error("unwritten pixel with nonzero address");

  // With the output register empty the input side never stalls.
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o && cfg_ready_o)
    else $error("input stalled with empty output");

  // An accepted pixel reaches the result register or finds it holding a stalled beat.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> ##1 out_valid_o)
    else $error("accepted pixel did not reach the output");

endmodule

bind clipped_keyed_blit ckb_checker u_ckb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .cfg_ready_o    (cfg_ready_o),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .write_enable_o (write_enable_o),
  .dest_address_o (dest_address_o),
  .dest_pixel_o   (dest_pixel_o),
  .frame_end_o    (frame_end_o)
);
